### design/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame sync package
// Shared types, constants and helpers for the five-byte frame checker.
// ----------------------------------------------------------------------------
package sfs_pkg;

  typedef logic [7:0] byte_t;

  // Window cells ahead of the byte that closes a frame
  localparam int unsigned WinDepth = 4;

  localparam byte_t ID_RESET  = 8'd163;
  localparam byte_t CH_MAX    = 8'd31;
  localparam byte_t CH_BCAST  = 8'd255;

  // Control shared by every cell of the window chain
  typedef struct packed {
    logic shift;  // take the neighbor's byte
    logic clear;  // empty the cell
  } cell_ctrl_t;

  function automatic logic channel_known(input byte_t ch);
    channel_known = ((ch != 8'd0) && (ch <= CH_MAX)) || (ch == CH_BCAST);
  endfunction

endpackage

### design/sfs_cell.sv
// ----------------------------------------------------------------------------
// Sensor frame sync window cell
// Holds one byte and its valid flag, shifts toward the oldest end, and
// adds its byte to the running checksum passed down the chain.
// ----------------------------------------------------------------------------
module sfs_cell
  import sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  byte_t      data_in,
  input  logic       valid_in,
  input  byte_t      sum_in,
  output byte_t      data_q,
  output logic       valid_q,
  output byte_t      sum_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl.shift) begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_q <= data_in;
    end
  end

  // Checksum wraps modulo 256
  assign sum_out = sum_in + data_q;

endmodule

### design/sensor_frame_sync_checker.sv
// ----------------------------------------------------------------------------
// Sensor frame sync checker
// Slides received bytes through a four-cell window; a fifth byte that
// matches the checksum, with the right ID byte, closes a frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   rx_byte
//  out      output     out_valid/out_stall channel_id, channel_value
//  cfg      input      cfg_valid/cfg_ready cfg_data (id_byte)
//
// One byte per cycle while the input is not stalled; the frame check is combinational over the window
// cells and the result is registered in the output register.
// Reset empties the window and loads id_byte with 163.
// Input stalls only while a result sits in the output register and the
// output is stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module sensor_frame_sync_checker
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  channel_id,
  output logic [15:0] channel_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  byte_t      id_byte;
  byte_t      cell_data [WinDepth];
  logic       cell_valid [WinDepth];
  byte_t      cell_sum [WinDepth+1];
  cell_ctrl_t ctrl;
  logic       in_accept;
  logic       win_full;
  logic       frame_ok;
  logic       emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_byte <= ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      id_byte <= cfg_data;
    end
  end

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign win_full = cell_valid[0] && cell_valid[1] && cell_valid[2] && cell_valid[3];
  assign frame_ok = (cell_data[1] == id_byte) && (rx_byte == cell_sum[WinDepth]);
  assign emit     = in_accept && win_full && frame_ok && channel_known(cell_data[0]);

  // Every accepted byte advances the chain; a good frame empties it
  assign ctrl.shift = in_accept;
  assign ctrl.clear = in_accept && win_full && frame_ok;

  assign cell_sum[0] = '0;

  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    byte_t next_data;
    logic  next_valid;
    if (i == WinDepth - 1) begin : g_tail
      assign next_data  = rx_byte;
      assign next_valid = 1'b1;
    end else begin : g_body
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end
    sfs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .data_in  (next_data),
      .valid_in (next_valid),
      .sum_in   (cell_sum[i]),
      .data_q   (cell_data[i]),
      .valid_q  (cell_valid[i]),
      .sum_out  (cell_sum[i+1])
    );
  end

  // Output register: load on a result, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel_id    <= cell_data[0];
      channel_value <= {cell_data[2], cell_data[3]};
    end
  end

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel_known(channel_id))
    else $error("result with unknown channel");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept))
    else $error("result without an accepted byte");

  a_clear_window: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> !cell_valid[0] && !cell_valid[1] && !cell_valid[2] && !cell_valid[3])
    else $error("window not emptied after a good frame");

  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    emit |-> win_full)
    else $error("result from a partial window");

endmodule
